@@ hdl/stp_pkg.sv @@
// Package for the stepper step sequencer: action codes, result bundle,
// reset constants and the full-step coil table. No dependencies.
`timescale 1ns / 1ps

package stp_pkg;

    // Default width of the tick and step counters.
    localparam int COUNT_BITS_DEF = 16;

    // Step period after reset, in ticks.
    localparam int RESET_PERIOD = 11;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_RUN  = 2'd2,
        ACT_STOP = 2'd3
    } stp_action_t;

    // One result item as it leaves the core.
    typedef struct packed {
        logic [3:0] coil_pattern;
        logic       stepped;
        logic       moving;
        logic       move_done;
    } stp_result_t;

    // Two-coils-on pattern for each phase, coil a in the LSB.
    function automatic logic [3:0] coil_of_phase(input logic [1:0] phase);
        logic [3:0] pattern;
        unique case (phase)
            2'd0: pattern = 4'h3;
            2'd1: pattern = 4'h6;
            2'd2: pattern = 4'hC;
            2'd3: pattern = 4'h9;
            default: pattern = 4'h3;
        endcase
        return pattern;
    endfunction

endpackage

@@ hdl/stp_core.sv @@
// Sequencer state and its update for one item.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_core
    import stp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [1:0]            action,
    input  logic [COUNT_BITS-1:0] period,
    input  logic                  dir,
    input  logic [COUNT_BITS-1:0] count,
    output stp_result_t           result
);

    logic [1:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] tick_reg, tick_next;
    logic [COUNT_BITS-1:0] period_reg, period_next;
    logic [COUNT_BITS-1:0] last_run_reg, last_run_next;
    logic                  running_reg, running_next;
    logic                  limited_reg, limited_next;
    logic                  dir_reg, dir_next;
    logic [COUNT_BITS-1:0] done_cnt_reg, done_cnt_next;
    logic [COUNT_BITS-1:0] target_reg, target_next;

    logic [COUNT_BITS-1:0] tick_inc;
    logic [COUNT_BITS-1:0] done_inc;
    logic                  stepped;
    logic                  move_done;

    assign tick_inc = tick_reg + COUNT_BITS'(1);
    assign done_inc = done_cnt_reg + COUNT_BITS'(1);

    // Decode the action and work out the next state.
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        period_next   = period_reg;
        last_run_next = last_run_reg;
        running_next  = running_reg;
        limited_next  = limited_reg;
        dir_next      = dir_reg;
        done_cnt_next = done_cnt_reg;
        target_next   = target_reg;
        stepped       = 1'b0;
        move_done     = 1'b0;

        unique case (stp_action_t'(action))
            ACT_MOVE:
            begin
                period_next   = period;
                dir_next      = dir;
                target_next   = count;
                done_cnt_next = '0;
                tick_next     = '0;
                limited_next  = 1'b1;
                // A move of zero steps finishes at once.
                running_next  = (count != '0);
                move_done     = (count == '0);
            end
            ACT_RUN:
            begin
                if (period != last_run_reg)
                begin
                    tick_next     = '0;
                    last_run_next = period;
                end
                period_next  = period;
                running_next = 1'b1;
                limited_next = 1'b0;
            end
            ACT_STOP:
            begin
                running_next = 1'b0;
            end
            ACT_TICK:
            begin
                if (running_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc == period_reg)
                    begin
                        tick_next     = '0;
                        phase_next    = dir_reg ? phase_reg + 2'd1 : phase_reg - 2'd1;
                        stepped       = 1'b1;
                        done_cnt_next = done_inc;
                        if (limited_reg && (done_inc >= target_reg))
                        begin
                            running_next = 1'b0;
                            move_done    = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    // Result of this item, shown after the update.
    always_comb
    begin
        result.coil_pattern = coil_of_phase(phase_next);
        result.stepped      = stepped;
        result.moving       = running_next;
        result.move_done    = move_done;
    end

    // State registers, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            tick_reg     <= '0;
            period_reg   <= COUNT_BITS'(RESET_PERIOD);
            last_run_reg <= '0;
            running_reg  <= 1'b0;
            limited_reg  <= 1'b0;
            dir_reg      <= 1'b0;
            done_cnt_reg <= '0;
            target_reg   <= '0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            period_reg   <= period_next;
            last_run_reg <= last_run_next;
            running_reg  <= running_next;
            limited_reg  <= limited_next;
            dir_reg      <= dir_next;
            done_cnt_reg <= done_cnt_next;
            target_reg   <= target_next;
        end
    end

endmodule

@@ hdl/stepper_step_sequencer_top.sv @@
// Top level of the stepper step sequencer: input register, core, result register.
// Depends on stp_pkg and stp_core.
`timescale 1ns / 1ps
//
//  Channel   Handshake               Fields
//  --------  ----------------------  ------------------------------------------------
//  command   cmd_valid / cmd_stall   action, step_period, turn_direction, step_count
//  result    res_valid / res_stall   coil_pattern, stepped, moving, move_done
//
//  Every accepted item gives exactly one result item, after passing through the input
//  register and then the result register. One item per cycle is sustained while
//  res_stall is low; the state update in the core sets that rate.
//  Reset clears the sequencer to phase 0, stopped, period 11 ticks.
//  When the result is stalled and both registers are full, cmd_stall rises.

module stepper_step_sequencer_top
    import stp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  action,
    input  logic [15:0] step_period,
    input  logic        turn_direction,
    input  logic [15:0] step_count,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [3:0]  coil_pattern,
    output logic        stepped,
    output logic        moving,
    output logic        move_done
);

    logic                  in_valid_reg;
    logic [1:0]            action_reg;
    logic [15:0]           period_in_reg;
    logic                  dir_in_reg;
    logic [15:0]           count_in_reg;
    logic                  res_valid_reg;
    stp_result_t           res_reg;
    stp_result_t           core_result;
    logic                  advance;
    logic                  cmd_accept;
    logic [COUNT_BITS+15:0] period_ext;
    logic [COUNT_BITS+15:0] count_ext;

    // The input item moves on when the result register is free or drains.
    assign advance    = in_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall  = in_valid_reg && !advance;
    assign cmd_accept = cmd_valid && !cmd_stall;

    // Fit the 16-bit fields to the counter width.
    assign period_ext = {{COUNT_BITS{1'b0}}, period_in_reg};
    assign count_ext  = {{COUNT_BITS{1'b0}}, count_in_reg};

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            action_reg    <= action;
            period_in_reg <= step_period;
            dir_in_reg    <= turn_direction;
            count_in_reg  <= step_count;
        end
    end

    stp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .action (action_reg),
        .period (period_ext[COUNT_BITS-1:0]),
        .dir    (dir_in_reg),
        .count  (count_ext[COUNT_BITS-1:0]),
        .result (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign res_valid    = res_valid_reg;
    assign coil_pattern = res_reg.coil_pattern;
    assign stepped      = res_reg.stepped;
    assign moving       = res_reg.moving;
    assign move_done    = res_reg.move_done;

endmodule

@@ verif/tb_stepper_step_sequencer_top.sv @@
// Self-checking testbench for stepper_step_sequencer_top: directed and random
// command streams, with a built-in predictor of phase, counters and coil pattern.
// Depends on stp_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_stepper_step_sequencer_top;
    import stp_pkg::*;

    localparam int CNT_W        = COUNT_BITS_DEF;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;
    localparam int RANDOM_ITEMS = 1250;

    // Receiver stall styles.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_style_t;

    // Coil pattern for each phase, coil a in the LSB.
    localparam logic [3:0] PHASE_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [1:0]  action = ACT_TICK;
    logic [15:0] step_period = '0;
    logic        turn_direction = 1'b0;
    logic [15:0] step_count = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [3:0]  coil_pattern;
    logic        stepped;
    logic        moving;
    logic        move_done;

    // Predicted sequencer state.
    logic [1:0]       seq_phase;
    logic [CNT_W-1:0] seq_ticks;
    logic [15:0]      seq_period;
    logic [15:0]      seq_last_run;
    logic             seq_running;
    logic             seq_limited;
    logic             seq_dir;
    logic [CNT_W-1:0] seq_steps;
    logic [CNT_W-1:0] seq_target;

    stp_result_t predicted_outputs[$];
    stp_result_t want;

    int mismatch_count   = 0;
    int items_sent       = 0;
    int results_seen     = 0;
    int steps_seen       = 0;
    int moves_seen       = 0;
    int input_held       = 0;
    int cycle_count      = 0;
    int burst_left       = 0;
    bit sender_gaps_on   = 1'b1;
    int hold_request     = 0;
    int hold_left        = 0;
    int mode_left        = 0;
    int pattern_step     = 0;
    stall_style_t stall_mode = STALL_NONE;

    stepper_step_sequencer_top #(
        .COUNT_BITS(CNT_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .action(action),
        .step_period(step_period),
        .turn_direction(turn_direction),
        .step_count(step_count),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .coil_pattern(coil_pattern),
        .stepped(stepped),
        .moving(moving),
        .move_done(move_done)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Cycle counter with the run limit; also counts cycles with the input held off.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cmd_valid && cmd_stall)
            input_held++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit, %0d results outstanding",
                     predicted_outputs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:  res_stall <= 1'b0;
                STALL_LIGHT: res_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY: res_stall <= 1'($urandom_range(0, 1));
                default:     res_stall <= ((pattern_step % 5) < 2);
            endcase
            pattern_step++;
            if (mode_left == 0)
            begin
                stall_mode = stall_style_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 120);
            end
            else
                mode_left--;
        end
    end

    // Count a mismatch and print its line, up to a cap.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (predicted_outputs.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                          results_seen));
            else
            begin
                want = predicted_outputs.pop_front();
                if (coil_pattern !== want.coil_pattern)
                    report_mismatch($sformatf("result %0d coil_pattern %h, predicted %h",
                                              results_seen, coil_pattern, want.coil_pattern));
                if (stepped !== want.stepped)
                    report_mismatch($sformatf("result %0d stepped %b, predicted %b",
                                              results_seen, stepped, want.stepped));
                if (moving !== want.moving)
                    report_mismatch($sformatf("result %0d moving %b, predicted %b",
                                              results_seen, moving, want.moving));
                if (move_done !== want.move_done)
                    report_mismatch($sformatf("result %0d move_done %b, predicted %b",
                                              results_seen, move_done, want.move_done));
            end
            results_seen++;
            if (stepped === 1'b1)
                steps_seen++;
            if (move_done === 1'b1)
                moves_seen++;
        end
    end

    // Sequencer state after reset.
    function automatic void clear_sequencer();
        seq_phase    = '0;
        seq_ticks    = '0;
        seq_period   = 16'(RESET_PERIOD);
        seq_last_run = '0;
        seq_running  = 1'b0;
        seq_limited  = 1'b0;
        seq_dir      = 1'b0;
        seq_steps    = '0;
        seq_target   = '0;
    endfunction

    // Apply one command item to the predicted state and queue its result.
    function automatic void advance_sequencer(input stp_action_t act, input logic [15:0] per,
                                              input logic dir, input logic [15:0] cnt);
        stp_result_t res;
        logic did_step;
        logic finished;
        did_step = 1'b0;
        finished = 1'b0;
        case (act)
            ACT_MOVE:
            begin
                seq_period  = per;
                seq_dir     = dir;
                seq_target  = CNT_W'(cnt);
                seq_steps   = '0;
                seq_ticks   = '0;
                seq_running = 1'b1;
                seq_limited = 1'b1;
                // A move of zero steps is finished as soon as it is loaded.
                if (seq_target == '0)
                begin
                    seq_running = 1'b0;
                    finished = 1'b1;
                end
            end
            ACT_RUN:
            begin
                // The counter keeps its value when the period equals the last run period.
                if (per != seq_last_run)
                begin
                    seq_ticks = '0;
                    seq_last_run = per;
                end
                seq_period  = per;
                seq_running = 1'b1;
                seq_limited = 1'b0;
            end
            ACT_STOP:
                seq_running = 1'b0;
            default:
            begin
                if (seq_running)
                begin
                    seq_ticks = seq_ticks + 1'b1;
                    if (seq_ticks == CNT_W'(seq_period))
                    begin
                        seq_ticks = '0;
                        seq_phase = seq_dir ? seq_phase + 2'd1 : seq_phase - 2'd1;
                        did_step = 1'b1;
                        seq_steps = seq_steps + 1'b1;
                        if (seq_limited && seq_steps >= seq_target)
                        begin
                            seq_running = 1'b0;
                            finished = 1'b1;
                        end
                    end
                end
            end
        endcase
        res.coil_pattern = PHASE_COILS[seq_phase];
        res.stepped      = did_step;
        res.moving       = seq_running;
        res.move_done    = finished;
        predicted_outputs.push_back(res);
    endfunction

    // Offer one item, hold it until accepted, then maybe open a gap.
    task automatic send_cmd(input stp_action_t act, input logic [15:0] per,
                            input logic dir, input logic [15:0] cnt);
        int gap;
        cmd_valid      <= 1'b1;
        action         <= act;
        step_period    <= per;
        turn_direction <= dir;
        step_count     <= cnt;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
        advance_sequencer(act, per, dir, cnt);
        if (sender_gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(0, 24);
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // A tick carries random content in the fields that it does not use.
    task automatic send_tick();
        send_cmd(ACT_TICK, 16'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // Pattern after reset, and a stop while nothing is moving.
    task automatic test_idle_after_reset();
        send_tick();
        send_cmd(ACT_STOP, 16'h0000, 1'b0, 16'h0000);
        send_tick();
    endtask

    // A move of zero steps finishes at once.
    task automatic test_zero_step_move();
        send_cmd(ACT_MOVE, 16'd1, 1'b1, 16'd0);
        send_tick();
    endtask

    // A short limited move counting up, then one more tick once it has stopped.
    task automatic test_limited_move();
        send_cmd(ACT_MOVE, 16'd1, 1'b1, 16'd3);
        repeat (4) send_tick();
    endtask

    // Run keeps its counter on an unchanged period and clears it on a new one.
    task automatic test_run_and_stop();
        send_cmd(ACT_RUN, 16'd2, 1'b0, 16'd0);
        send_tick();
        send_cmd(ACT_RUN, 16'd2, 1'b1, 16'hFFFF);
        send_tick();
        send_cmd(ACT_RUN, 16'd3, 1'b0, 16'd0);
        send_tick();
        send_cmd(ACT_STOP, 16'hFFFF, 1'b1, 16'hFFFF);
        send_tick();
    endtask

    // Field extremes: longest period and count counting down, then period zero.
    task automatic test_field_extremes();
        send_cmd(ACT_MOVE, 16'hFFFF, 1'b0, 16'hFFFF);
        send_tick();
        send_cmd(ACT_RUN, 16'h0000, 1'b1, 16'h0000);
        send_tick();
        send_cmd(ACT_STOP, 16'h0000, 1'b0, 16'h0000);
    endtask

    // Long receiver hold-off while the sender keeps offering items back to back.
    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        hold_request = 150;
        send_cmd(ACT_RUN, 16'd1, 1'b1, 16'd0);
        repeat (40) send_tick();
        send_cmd(ACT_STOP, 16'd0, 1'b0, 16'd0);
        sender_gaps_on = 1'b1;
    endtask

    // Mostly well-formed moves and runs with random content, plus noise.
    task automatic test_random_sequences(input int n_items);
        int kind;
        int ticks;
        logic [15:0] per;
        logic [15:0] cnt;
        logic dir;
        logic [15:0] prev_run;
        prev_run = 16'd1;
        while (items_sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                // Limited move, usually run to completion.
                per = 16'($urandom_range(1, 6));
                cnt = 16'($urandom_range(0, 8));
                dir = 1'($urandom_range(0, 1));
                send_cmd(ACT_MOVE, per, dir, cnt);
                ticks = per * cnt + $urandom_range(0, 4);
                if ($urandom_range(0, 7) == 0)
                    ticks = ticks / 2;
                repeat (ticks) send_tick();
                if ($urandom_range(0, 5) == 0)
                    send_cmd(ACT_RUN, prev_run, 1'($urandom), 16'($urandom));
            end
            else if (kind < 7)
            begin
                // Continuous run, sometimes at the previous run period.
                if ($urandom_range(0, 3) == 0)
                    per = prev_run;
                else
                    per = 16'($urandom_range(1, 8));
                prev_run = per;
                send_cmd(ACT_RUN, per, 1'($urandom), 16'($urandom));
                repeat ($urandom_range(3, 30)) send_tick();
                if ($urandom_range(0, 2) == 0)
                begin
                    per = ($urandom_range(0, 1) == 0) ? prev_run : 16'($urandom_range(1, 8));
                    prev_run = per;
                    send_cmd(ACT_RUN, per, 1'($urandom), 16'($urandom));
                    repeat ($urandom_range(1, 12)) send_tick();
                end
                if ($urandom_range(0, 1) == 0)
                    send_cmd(ACT_STOP, 16'($urandom), 1'($urandom), 16'($urandom));
            end
            else if (kind < 9)
            begin
                // Noise: any action with full-range fields.
                send_cmd(stp_action_t'($urandom_range(0, 3)), 16'($urandom),
                         1'($urandom), 16'($urandom));
                repeat ($urandom_range(0, 3)) send_tick();
            end
            else
                repeat ($urandom_range(1, 6)) send_tick();
        end
    endtask

    // Main sequence: reset, directed tests, random tests, drain and verdict.
    initial
    begin
        clear_sequencer();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_zero_step_move();
        test_limited_move();
        test_run_and_stop();
        test_field_extremes();
        test_backpressure();
        test_random_sequences(items_sent + RANDOM_ITEMS);

        cmd_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_outputs.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      predicted_outputs.size()));

        $display("Sent %0d items and checked %0d results: %0d steps, %0d moves finished.",
                 items_sent, results_seen, steps_seen, moves_seen);
        $display("Input was held off for %0d cycles; %0d mismatches in %0d cycles.",
                 input_held, mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
